// ===== hdl/pressure_sensor_compensation_unit_assert.svh =====
// assertion macros used by the compensation datapath module
`ifndef PRESSURE_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// condition that must hold at every edge out of reset
`define PSC_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// same-cycle implication
`define PSC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/psc_pkg.sv =====
// types and constants of the pressure sensor compensation unit
package psc_pkg;

  localparam int unsigned CalWidth   = 16;
  localparam int unsigned RawWidth   = 24;
  localparam int unsigned TempWidth  = 15;
  localparam int unsigned PresWidth  = 19;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned NumStages  = 8;

  localparam int TempKnee = 2000;
  localparam int TempLow  = -4000;
  localparam int TempHigh = 8500;
  localparam int PresHigh = 300000;

  typedef enum logic [2:0] {
    REG_PRESSURE_SENSITIVITY    = 3'd0,
    REG_PRESSURE_OFFSET         = 3'd1,
    REG_TEMP_COEFF_SENS         = 3'd2,
    REG_TEMP_COEFF_OFFSET       = 3'd3,
    REG_REFERENCE_TEMPERATURE   = 3'd4,
    REG_TEMPERATURE_SENSITIVITY = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CalWidth-1:0] pressure_sensitivity;
    logic [CalWidth-1:0] pressure_offset;
    logic [CalWidth-1:0] temp_coeff_sens;
    logic [CalWidth-1:0] temp_coeff_offset;
    logic [CalWidth-1:0] reference_temperature;
    logic [CalWidth-1:0] temperature_sensitivity;
  } cal_t;

  typedef struct packed {
    logic [RawWidth-1:0] raw_pressure;
    logic [RawWidth-1:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature_centi;
    logic [PresWidth-1:0]        pressure_centi_mbar;
    logic                        out_of_range;
  } out_item_t;

endpackage

// ===== hdl/psc_cfg_regs.sv =====
// calibration word register file behind the apb port
module psc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psc_pkg::AddrWidth-1:0]  paddr,
  input  logic [psc_pkg::DataWidth-1:0]  pwdata,
  output logic [psc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output psc_pkg::cal_t                  cal_o
);

  psc_pkg::cal_t     cal_q, cal_d;
  psc_pkg::reg_idx_e idx;
  logic              wr_en;
  logic [psc_pkg::CalWidth-1:0] rd_val;

  assign idx    = psc_pkg::reg_idx_e'(paddr[psc_pkg::AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (wr_en) begin
      case (idx)
        psc_pkg::REG_PRESSURE_SENSITIVITY:
          cal_d.pressure_sensitivity = pwdata[psc_pkg::CalWidth-1:0];
        psc_pkg::REG_PRESSURE_OFFSET:
          cal_d.pressure_offset = pwdata[psc_pkg::CalWidth-1:0];
        psc_pkg::REG_TEMP_COEFF_SENS:
          cal_d.temp_coeff_sens = pwdata[psc_pkg::CalWidth-1:0];
        psc_pkg::REG_TEMP_COEFF_OFFSET:
          cal_d.temp_coeff_offset = pwdata[psc_pkg::CalWidth-1:0];
        psc_pkg::REG_REFERENCE_TEMPERATURE:
          cal_d.reference_temperature = pwdata[psc_pkg::CalWidth-1:0];
        psc_pkg::REG_TEMPERATURE_SENSITIVITY:
          cal_d.temperature_sensitivity = pwdata[psc_pkg::CalWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      psc_pkg::REG_PRESSURE_SENSITIVITY:    rd_val = cal_q.pressure_sensitivity;
      psc_pkg::REG_PRESSURE_OFFSET:         rd_val = cal_q.pressure_offset;
      psc_pkg::REG_TEMP_COEFF_SENS:         rd_val = cal_q.temp_coeff_sens;
      psc_pkg::REG_TEMP_COEFF_OFFSET:       rd_val = cal_q.temp_coeff_offset;
      psc_pkg::REG_REFERENCE_TEMPERATURE:   rd_val = cal_q.reference_temperature;
      psc_pkg::REG_TEMPERATURE_SENSITIVITY: rd_val = cal_q.temperature_sensitivity;
      default:                              rd_val = '0;
    endcase
  end

  assign prdata = {{(psc_pkg::DataWidth-psc_pkg::CalWidth){1'b0}}, rd_val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

// ===== hdl/psc_datapath.sv =====
// eight-stage compensation datapath with per-stage flow control
`include "pressure_sensor_compensation_unit_assert.svh"

module psc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psc_pkg::cal_t       cal_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psc_pkg::out_item_t  out_data_o
);

  localparam int unsigned NStg = psc_pkg::NumStages;

  localparam logic signed [19:0] KneeW     = 20'(psc_pkg::TempKnee);
  localparam logic signed [20:0] TempLowW  = 21'(psc_pkg::TempLow);
  localparam logic signed [20:0] TempHighW = 21'(psc_pkg::TempHigh);
  localparam logic signed [31:0] PresHighW = 32'(psc_pkg::PresHigh);

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  // a stage loads when empty or when its successor moves
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  // stage 1: dT
  logic signed [24:0] s1_dt_q, s1_dt_d;
  logic [23:0]        s1_d1_q;
  logic signed [25:0] dt_wide;

  assign dt_wide = $signed({2'b0, in_data_i.raw_temperature})
                 - $signed({2'b0, cal_i.reference_temperature, 8'b0});
  assign s1_dt_d = 25'(dt_wide);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= in_data_i.raw_pressure;
    end
  end

  // stage 2: coefficient products and dT squared
  logic signed [41:0] s2_pt_q, s2_po_q, s2_ps_q, s2_pt_d, s2_po_d, s2_ps_d;
  logic signed [49:0] s2_sq_q, s2_sq_d;
  logic [23:0]        s2_d1_q;

  assign s2_pt_d = s1_dt_q * $signed({1'b0, cal_i.temperature_sensitivity});
  assign s2_po_d = s1_dt_q * $signed({1'b0, cal_i.temp_coeff_offset});
  assign s2_ps_d = s1_dt_q * $signed({1'b0, cal_i.temp_coeff_sens});
  assign s2_sq_d = s1_dt_q * s1_dt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_pt_q <= s2_pt_d;
      s2_po_q <= s2_po_d;
      s2_ps_q <= s2_ps_d;
      s2_sq_q <= s2_sq_d;
      s2_d1_q <= s1_d1_q;
    end
  end

  // stage 3: first-order temp, offset, sensitivity
  logic signed [18:0] s3_dev_q, s3_dev_d;
  logic signed [19:0] s3_temp_q, s3_temp_d;
  logic signed [37:0] s3_off_q, s3_off_d, s3_sens_q, s3_sens_d;
  logic signed [20:0] s3_ti_q, s3_ti_d;
  logic               s3_low_q, s3_low_d;
  logic [23:0]        s3_d1_q;
  logic signed [53:0] sq11;
  logic signed [41:0] pt_sh, po_sh, ps_sh;

  assign pt_sh     = s2_pt_q >>> 23;
  assign po_sh     = s2_po_q >>> 6;
  assign ps_sh     = s2_ps_q >>> 7;
  assign s3_dev_d  = 19'(pt_sh);
  assign s3_temp_d = KneeW + 20'(s3_dev_d);
  assign s3_low_d  = s3_dev_d[18];
  assign s3_off_d  = 38'($signed({5'b0, cal_i.pressure_offset, 17'b0}) + po_sh);
  assign s3_sens_d = 38'($signed({6'b0, cal_i.pressure_sensitivity, 16'b0}) + ps_sh);
  assign sq11      = s2_sq_q * 54'sd11;
  assign s3_ti_d   = 21'(sq11 >>> 35);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_dev_q  <= s3_dev_d;
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_ti_q   <= s3_ti_d;
      s3_low_q  <= s3_low_d;
      s3_d1_q   <= s2_d1_q;
    end
  end

  // stage 4: square of the temperature deviation
  logic signed [37:0] s4_sq_q, s4_sq_d;
  logic signed [19:0] s4_temp_q;
  logic signed [37:0] s4_off_q, s4_sens_q;
  logic signed [20:0] s4_ti_q;
  logic               s4_low_q;
  logic [23:0]        s4_d1_q;

  assign s4_sq_d = s3_dev_q * s3_dev_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_sq_q   <= s4_sq_d;
      s4_temp_q <= s3_temp_q;
      s4_off_q  <= s3_off_q;
      s4_sens_q <= s3_sens_q;
      s4_ti_q   <= s3_ti_q;
      s4_low_q  <= s3_low_q;
      s4_d1_q   <= s3_d1_q;
    end
  end

  // stage 5: second-order correction below 20.00 C
  logic signed [41:0] sq31, sq63;
  logic signed [39:0] s5_off_q, s5_off_d, s5_sens_q, s5_sens_d;
  logic signed [20:0] s5_temp_q, s5_temp_d;
  logic [23:0]        s5_d1_q;

  assign sq31 = s4_sq_q * 42'sd31;
  assign sq63 = s4_sq_q * 42'sd63;

  always_comb begin
    if (s4_low_q) begin
      s5_off_d  = 40'(s4_off_q - (sq31 >>> 3));
      s5_sens_d = 40'(s4_sens_q - (sq63 >>> 5));
      s5_temp_d = 21'(s4_temp_q) - s4_ti_q;
    end else begin
      s5_off_d  = 40'(s4_off_q);
      s5_sens_d = 40'(s4_sens_q);
      s5_temp_d = 21'(s4_temp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_off_q  <= s5_off_d;
      s5_sens_q <= s5_sens_d;
      s5_temp_q <= s5_temp_d;
      s5_d1_q   <= s4_d1_q;
    end
  end

  // stage 6: D1 times SENS as two partial products
  logic signed [45:0] s6_pl_q, s6_pl_d, s6_ph_q, s6_ph_d;
  logic signed [39:0] s6_off_q;
  logic signed [20:0] s6_temp_q;

  assign s6_pl_d = $signed({1'b0, s5_d1_q}) * $signed({1'b0, s5_sens_q[19:0]});
  assign s6_ph_d = $signed({1'b0, s5_d1_q}) * $signed(s5_sens_q[39:20]);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_pl_q   <= s6_pl_d;
      s6_ph_q   <= s6_ph_d;
      s6_off_q  <= s5_off_q;
      s6_temp_q <= s5_temp_q;
    end
  end

  // stage 7: combine partial products, scale by 2^-21
  logic signed [65:0] prod;
  logic signed [44:0] s7_p21_q, s7_p21_d;
  logic signed [39:0] s7_off_q;
  logic signed [20:0] s7_temp_q;

  assign prod     = (66'(s6_ph_q) <<< 20) + 66'(s6_pl_q);
  assign s7_p21_d = 45'(prod >>> 21);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_p21_q  <= s7_p21_d;
      s7_off_q  <= s6_off_q;
      s7_temp_q <= s6_temp_q;
    end
  end

  // stage 8: pressure and clamping into the output register
  logic signed [46:0] pdiff;
  logic signed [31:0] pres;
  psc_pkg::out_item_t out_q, out_d;

  assign pdiff = 47'(s7_p21_q) - 47'(s7_off_q);
  assign pres  = 32'(pdiff >>> 15);

  always_comb begin
    out_d.out_of_range = 1'b0;
    if (s7_temp_q < TempLowW) begin
      out_d.temperature_centi = psc_pkg::TempWidth'(TempLowW);
      out_d.out_of_range      = 1'b1;
    end else if (s7_temp_q > TempHighW) begin
      out_d.temperature_centi = psc_pkg::TempWidth'(TempHighW);
      out_d.out_of_range      = 1'b1;
    end else begin
      out_d.temperature_centi = psc_pkg::TempWidth'(s7_temp_q);
    end
    if (pres < 32'sd0) begin
      out_d.pressure_centi_mbar = '0;
      out_d.out_of_range        = 1'b1;
    end else if (pres > PresHighW) begin
      out_d.pressure_centi_mbar = psc_pkg::PresWidth'(PresHighW);
      out_d.out_of_range        = 1'b1;
    end else begin
      out_d.pressure_centi_mbar = psc_pkg::PresWidth'(pres);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NStg-1]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  `PSC_ASSERT_IMPL(a_temp_range, clk_i, rst_ni, out_valid_o, (out_q.temperature_centi >= 15'sd0 - 15'sd4000) && (out_q.temperature_centi <= 15'sd8500), "temperature outside clamp range")
  `PSC_ASSERT_IMPL(a_pres_range, clk_i, rst_ni, out_valid_o, out_q.pressure_centi_mbar <= psc_pkg::PresWidth'(PresHighW), "pressure outside clamp range")
  `PSC_ASSERT_IMPL(a_flag_bound, clk_i, rst_ni, out_valid_o && out_q.out_of_range, (out_q.temperature_centi == psc_pkg::TempWidth'(TempLowW)) || (out_q.temperature_centi == psc_pkg::TempWidth'(TempHighW)) || (out_q.pressure_centi_mbar == '0) || (out_q.pressure_centi_mbar == psc_pkg::PresWidth'(PresHighW)), "clamp flag without a bound value")
  `PSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, v_q[NStg-1] && !en[NStg-1], v_q[NStg-1] && $stable(out_q), "stalled result changed")

endmodule

// ===== hdl/pressure_sensor_compensation_unit.sv =====
// top level of the barometric second-order compensation unit
// throughput: one request per cycle while the output is not stalled, eight register stages with per-stage flow control
// a stalled output holds its stage; earlier stages keep filling until the pipe is full
// reset: rst_ni asynchronous active low, clears stage valid bits and calibration words
// calibration words read back over apb; writes to unknown offsets are ignored
module pressure_sensor_compensation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psc_pkg::AddrWidth-1:0]  paddr,
  input  logic [psc_pkg::DataWidth-1:0]  pwdata,
  output logic [psc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  psc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output psc_pkg::out_item_t             out_data_o
);

  psc_pkg::cal_t cal;

  psc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  psc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
